@@ src/iol_pkg.sv @@
// ----------------------------------------------------------------------------
// iol_pkg
// Shared types, sizes and word conversion helpers for the ordered list block.
// ----------------------------------------------------------------------------
package iol_pkg;

	// list sizing
	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;

	// fixed field widths of the command and response beats
	localparam int POS_BITS   = 5;
	localparam int VAL_BITS   = 32;
	localparam int AT_BITS    = 4;
	localparam int LEN_BITS   = 5;

	// derived widths
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
	localparam int CONV_W = (WORD_BITS > VAL_BITS) ? WORD_BITS : VAL_BITS;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [2:0] {
		OP_PUSH    = 3'd0,
		OP_APPEND  = 3'd1,
		OP_INSERT  = 3'd2,
		OP_GET     = 3'd3,
		OP_REMOVE  = 3'd4,
		OP_SEARCH  = 3'd5,
		OP_POP     = 3'd6,
		OP_CLEAR   = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	// what a cell does at the next edge
	typedef enum logic [1:0] {
		CM_HOLD    = 2'd0,
		CM_LOAD    = 2'd1,
		CM_TAKE_LO = 2'd2,
		CM_TAKE_HI = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       live;
	} cell_ctl_t;

	typedef struct packed {
		op_t                        op;
		logic [POS_BITS-1:0]        position;
		logic signed [VAL_BITS-1:0] value;
	} cmd_beat_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VAL_BITS-1:0] read_value;
		logic [AT_BITS-1:0]         found_at;
		logic [LEN_BITS-1:0]        length;
	} rsp_beat_t;

	// low word bits of a field value, zero extended if the word is wider
	function automatic word_t to_word(logic [VAL_BITS-1:0] v);
		logic [CONV_W-1:0] tmp;
		tmp = CONV_W'(v);
		return tmp[WORD_BITS-1:0];
	endfunction

	// stored word back to the field width
	function automatic logic [VAL_BITS-1:0] to_field(word_t w);
		logic [CONV_W-1:0] tmp;
		tmp = CONV_W'(w);
		return tmp[VAL_BITS-1:0];
	endfunction

endpackage

@@ src/indexed_ordered_list.sv @@
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Bounded ordered list of words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// response: the response strobe is registered and comes in the cycle after the command beat
// throughput: one command per cycle; the cell row shifts or loads every
//   slot at the same edge and compares all slots combinationally
// reset: length cleared, busy held high during reset and cleared on a clock edge
//   after its release, cell contents undefined until written; responses cannot
//   be stalled
module indexed_ordered_list import iol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cmd_beat_t cmd,
	output logic      done,
	output rsp_beat_t rsp
);

	logic              busy_q;
	logic              done_q;
	rsp_beat_t         rsp_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;

	logic              accept;
	logic              full;
	logic [CMP_W-1:0]  pos_w;
	logic [CMP_W-1:0]  cnt_w;
	logic [CMP_W-1:0]  epos;
	logic              ins;
	logic              rem;
	status_t           status;
	word_t             rd_word;
	logic [IDX_W-1:0]  at_idx;
	rsp_beat_t         rsp_d;

	word_t             key;
	word_t             cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	cell_ctl_t         cell_ctl [CAPACITY];
	word_t             scan_rd;
	logic              scan_any;
	logic [IDX_W-1:0]  scan_first;
	logic [CMP_W-1:0]  at_w;
	logic [CMP_W-1:0]  len_w;

	assign accept = start && !busy_q;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign pos_w  = CMP_W'(cmd.position);
	assign cnt_w  = CMP_W'(count_q);
	assign key    = to_word(cmd.value);

	// command decode and status
	always_comb begin
		status  = ST_OK;
		rd_word = '0;
		at_idx  = '0;
		ins     = 1'b0;
		rem     = 1'b0;
		epos    = '0;
		count_d = count_q;
		unique case (cmd.op)
			OP_PUSH: begin
				if (full) status = ST_FULL;
				else ins = 1'b1;
			end
			OP_APPEND: begin
				if (full) status = ST_FULL;
				else begin
					ins  = 1'b1;
					epos = cnt_w;
				end
			end
			OP_INSERT: begin
				if (pos_w > cnt_w) status = ST_RANGE;
				else if (full) status = ST_FULL;
				else begin
					ins  = 1'b1;
					epos = pos_w;
				end
			end
			OP_GET: begin
				if (pos_w >= cnt_w) status = ST_RANGE;
				else rd_word = scan_rd;
			end
			OP_REMOVE: begin
				if (count_q == '0) status = ST_MISS;
				else if (pos_w >= cnt_w) status = ST_RANGE;
				else begin
					rem  = 1'b1;
					epos = pos_w;
				end
			end
			OP_SEARCH: begin
				if (scan_any) at_idx = scan_first;
				else status = ST_MISS;
			end
			OP_POP: begin
				if (count_q == '0) status = ST_MISS;
				else rem = 1'b1;
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status = ST_OK;
			end
		endcase
		if (ins) count_d = count_q + CNT_W'(1);
		if (rem) count_d = count_q - CNT_W'(1);
	end

	// response beat
	assign at_w  = CMP_W'(at_idx);
	assign len_w = CMP_W'(count_d);
	always_comb begin
		rsp_d.status     = status;
		rsp_d.read_value = to_field(rd_word);
		rsp_d.found_at   = at_w[AT_BITS-1:0];
		rsp_d.length     = len_w[LEN_BITS-1:0];
	end

	// cell row
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		word_t lo;
		word_t hi;

		if (k == 0) begin : g_lo_edge
			assign lo = '0;
		end else begin : g_lo
			assign lo = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_hi_edge
			assign hi = '0;
		end else begin : g_hi
			assign hi = cell_data[k+1];
		end

		// per slot shift control
		always_comb begin
			cell_ctl[k].live = (CMP_W'(k) < cnt_w);
			cell_ctl[k].mode = CM_HOLD;
			if (accept && ins) begin
				if (CMP_W'(k) > epos) cell_ctl[k].mode = CM_TAKE_LO;
				else if (CMP_W'(k) == epos) cell_ctl[k].mode = CM_LOAD;
			end else if (accept && rem) begin
				if (CMP_W'(k) >= epos) cell_ctl[k].mode = CM_TAKE_HI;
			end
		end

		iol_cell u_cell (
			.clk  (clk),
			.ctl  (cell_ctl[k]),
			.din  (key),
			.lo   (lo),
			.hi   (hi),
			.key  (key),
			.data (cell_data[k]),
			.hit  (cell_hit[k])
		);
	end

	iol_scan u_scan (
		.data      (cell_data),
		.hits      (cell_hit),
		.rd_idx    (pos_w[IDX_W-1:0]),
		.rd_data   (scan_rd),
		.any_hit   (scan_any),
		.first_idx (scan_first)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) count_q <= count_d;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) rsp_q <= rsp_d;
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command gave no response");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("response without a command");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp_q.status == ST_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full status on a list that is not full");

endmodule

@@ src/iol_cell.sv @@
// ----------------------------------------------------------------------------
// iol_cell
// One list slot: holds a word, loads, shifts from either neighbor, compares.
// ----------------------------------------------------------------------------
module iol_cell import iol_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  word_t     din,
	input  word_t     lo,
	input  word_t     hi,
	input  word_t     key,
	output word_t     data,
	output logic      hit
);

	word_t data_q;

	// slot update
	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			CM_LOAD:    data_q <= din;
			CM_TAKE_LO: data_q <= lo;
			CM_TAKE_HI: data_q <= hi;
			default:    data_q <= data_q;
		endcase
	end

	// key compare, only for occupied slots
	assign data = data_q;
	assign hit  = ctl.live && (data_q == key);

endmodule

@@ src/iol_scan.sv @@
// ----------------------------------------------------------------------------
// iol_scan
// Read select and first-match priority encoder over the cell row.
// ----------------------------------------------------------------------------
module iol_scan import iol_pkg::*; (
	input  word_t             data [CAPACITY],
	input  logic [CAPACITY-1:0] hits,
	input  logic [IDX_W-1:0]  rd_idx,
	output word_t             rd_data,
	output logic              any_hit,
	output logic [IDX_W-1:0]  first_idx
);

	// get read select
	assign rd_data = data[rd_idx];
	assign any_hit = |hits;

	// lowest matching position wins
	always_comb begin
		first_idx = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (hits[k]) begin
				first_idx = IDX_W'(k);
			end
		end
	end

endmodule

@@ verif/tb_indexed_ordered_list.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_ordered_list
// Self-checking bench for the bounded ordered list. A queue of commands feeds
// a driver that sends them in bursts; a monitor keeps a shadow copy of the
// list, predicts each response as its command is taken and compares every
// response beat field by field in order.
// ----------------------------------------------------------------------------
module tb_indexed_ordered_list import iol_pkg::*; ();

	localparam int RANDOM_ITEMS = 1450;
	localparam int BURST_MAX    = 30;
	localparam int GAP_MAX      = 12;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 4;
	localparam logic [VAL_BITS-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [VAL_BITS-1:0] WORD_MAX = 32'h7fff_ffff;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	cmd_beat_t cmd;
	logic      done;
	rsp_beat_t rsp;

	// commands not yet taken, responses not yet seen
	cmd_beat_t pending_cmds[$];
	rsp_beat_t awaited_rsp[$];

	// shadow list used for prediction
	word_t shadow_words[CAPACITY];
	int    shadow_len;

	// stimulus side bookkeeping
	int                  gen_len;
	bit                  grow_mode;
	logic [VAL_BITS-1:0] value_pool[8];

	int burst_left;
	int gap_left;
	int idle_cycles;
	int errors;
	int n_cmds;
	int n_rsps;
	int op_seen[8];
	int status_seen[4];

	indexed_ordered_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.rsp    (rsp)
	);

	// response of the list to one command, updating the shadow copy
	function automatic rsp_beat_t list_response(cmd_beat_t c);
		rsp_beat_t r;
		word_t     key;
		int        p;
		r        = '0;
		r.status = ST_OK;
		key      = c.value;
		p        = c.position;
		case (c.op)
			OP_PUSH, OP_APPEND, OP_INSERT: begin
				if (c.op == OP_PUSH)
					p = 0;
				else if (c.op == OP_APPEND)
					p = shadow_len;
				if (p > shadow_len)
					r.status = ST_RANGE;
				else if (shadow_len >= CAPACITY)
					r.status = ST_FULL;
				else begin
					for (int k = shadow_len; k > p; k--)
						shadow_words[k] = shadow_words[k-1];
					shadow_words[p] = key;
					shadow_len++;
				end
			end
			OP_GET: begin
				if (p >= shadow_len)
					r.status = ST_RANGE;
				else
					r.read_value = shadow_words[p];
			end
			OP_REMOVE, OP_POP: begin
				if (c.op == OP_POP)
					p = 0;
				if (shadow_len == 0)
					r.status = ST_MISS;
				else if (p >= shadow_len)
					r.status = ST_RANGE;
				else begin
					for (int k = p; k + 1 < shadow_len; k++)
						shadow_words[k] = shadow_words[k+1];
					shadow_len--;
				end
			end
			OP_SEARCH: begin
				r.status = ST_MISS;
				for (int k = 0; k < shadow_len; k++) begin
					if (r.status == ST_MISS && shadow_words[k] == key) begin
						r.status   = ST_OK;
						r.found_at = AT_BITS'(k);
					end
				end
			end
			default: shadow_len = 0;
		endcase
		r.length = LEN_BITS'(shadow_len);
		return r;
	endfunction

	// queue one command and track the list length it leaves behind
	task automatic queue_cmd(op_t op, int pos, logic [VAL_BITS-1:0] v);
		cmd_beat_t c;
		c.op       = op;
		c.position = POS_BITS'(pos);
		c.value    = v;
		pending_cmds.push_back(c);
		case (op)
			OP_PUSH, OP_APPEND: if (gen_len < CAPACITY) gen_len++;
			OP_INSERT:          if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
			OP_REMOVE:          if (pos < gen_len) gen_len--;
			OP_POP:             if (gen_len > 0) gen_len--;
			OP_CLEAR:           gen_len = 0;
			default:            ;
		endcase
	endtask

	// half repeated values so searches hit, the rest extremes and full random
	function automatic logic [VAL_BITS-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return value_pool[$urandom_range(0, 7)];
		if (roll == 5) begin
			case ($urandom_range(0, 3))
				0:       return WORD_MIN;
				1:       return WORD_MAX;
				2:       return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	// positions mostly inside 0..span, sometimes anywhere in 0..CAPACITY
	function automatic int pick_pos(int span);
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, span);
		return $urandom_range(0, CAPACITY);
	endfunction

	// random commands in grow and shrink phases so the list fills and drains
	task automatic queue_random(int n);
		int   roll;
		int   pos;
		op_t  op;
		for (int i = 0; i < n; i++) begin
			if (grow_mode && gen_len == CAPACITY && $urandom_range(0, 7) == 0)
				grow_mode = 0;
			else if (!grow_mode && gen_len == 0 && $urandom_range(0, 3) == 0)
				grow_mode = 1;
			else if ($urandom_range(0, 39) == 0)
				grow_mode = !grow_mode;
			roll = $urandom_range(0, 99);
			if (grow_mode) begin
				if (roll < 18)      op = OP_PUSH;
				else if (roll < 36) op = OP_APPEND;
				else if (roll < 60) op = OP_INSERT;
				else if (roll < 72) op = OP_GET;
				else if (roll < 84) op = OP_SEARCH;
				else if (roll < 91) op = OP_REMOVE;
				else if (roll < 98) op = OP_POP;
				else                op = OP_CLEAR;
			end else begin
				if (roll < 5)       op = OP_PUSH;
				else if (roll < 10) op = OP_APPEND;
				else if (roll < 20) op = OP_INSERT;
				else if (roll < 35) op = OP_GET;
				else if (roll < 50) op = OP_SEARCH;
				else if (roll < 75) op = OP_REMOVE;
				else if (roll < 97) op = OP_POP;
				else                op = OP_CLEAR;
			end
			if (op == OP_INSERT)
				pos = pick_pos(gen_len);
			else if ((op == OP_GET || op == OP_REMOVE) && gen_len > 0)
				pos = pick_pos(gen_len - 1);
			else
				pos = $urandom_range(0, CAPACITY);
			queue_cmd(op, pos, pick_value());
		end
	endtask

	// hold off until every queued command has its response
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || awaited_rsp.size() != 0);
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// command driver, bursts of beats with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				start <= 1'b1;
				cmd   <= pending_cmds[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// response monitor, prediction on each command beat, idle watchdog
	always @(posedge clk) begin : monitor
		rsp_beat_t want;
		bit        moved;
		moved = 0;
		if (arst_n) begin
			// check the response beat against the oldest prediction
			if (done === 1'b1) begin
				moved = 1;
				n_rsps++;
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t: response with nothing outstanding, expected none, actual %p",
						$time, rsp);
				end else begin
					want = awaited_rsp.pop_front();
					report_field("status", want.status, rsp.status);
					report_field("read_value", want.read_value, rsp.read_value);
					report_field("found_at", want.found_at, rsp.found_at);
					report_field("length", want.length, rsp.length);
				end
			end
			// command beat taken: predict its response
			if (start && busy === 1'b0) begin
				moved = 1;
				want  = list_response(cmd);
				awaited_rsp.push_back(want);
				void'(pending_cmds.pop_front());
				n_cmds++;
				op_seen[cmd.op]++;
				status_seen[want.status]++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, BURST_MAX);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
				end
			end
			// watchdog on cycles with no beat in either direction
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// reset, stimulus and end of run
	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		cmd         = '0;
		shadow_len  = 0;
		gen_len     = 0;
		grow_mode   = 1;
		burst_left  = $urandom_range(1, BURST_MAX);
		gap_left    = 0;
		idle_cycles = 0;
		errors      = 0;
		n_cmds      = 0;
		n_rsps      = 0;
		for (int i = 0; i < 8; i++) begin
			op_seen[i]    = 0;
			value_pool[i] = $urandom;
		end
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;
		value_pool[0] = WORD_MIN;
		value_pool[1] = WORD_MAX;

		// clear, pop, remove, get and search on an empty list
		queue_cmd(OP_CLEAR, 0, '0);
		queue_cmd(OP_POP, 0, '0);
		queue_cmd(OP_REMOVE, 0, '0);
		queue_cmd(OP_GET, 0, '0);
		queue_cmd(OP_SEARCH, 0, '0);
		// build up with extremes, insert at zero, at the length and past it
		queue_cmd(OP_PUSH, 0, WORD_MIN);
		queue_cmd(OP_APPEND, 0, WORD_MAX);
		queue_cmd(OP_INSERT, 1, '0);
		queue_cmd(OP_INSERT, 0, '1);
		queue_cmd(OP_INSERT, 4, 32'h5555_aaaa);
		queue_cmd(OP_INSERT, 6, 32'h1111_1111);
		while (gen_len < CAPACITY)
			queue_cmd(OP_APPEND, 0, $urandom);
		// full list rejects every kind of growth; then reads, searches, removes, pop and clear
		queue_cmd(OP_PUSH, 0, 32'h0bad_0001);
		queue_cmd(OP_APPEND, 0, 32'h0bad_0002);
		queue_cmd(OP_INSERT, CAPACITY, 32'h0bad_0003);
		queue_cmd(OP_INSERT, 3, 32'h0bad_0004);
		queue_cmd(OP_GET, CAPACITY - 1, '0);
		queue_cmd(OP_GET, CAPACITY, '0);
		queue_cmd(OP_SEARCH, 0, WORD_MAX);
		queue_cmd(OP_SEARCH, 0, 32'h0bad_0003);
		queue_cmd(OP_REMOVE, CAPACITY, '0);
		queue_cmd(OP_REMOVE, CAPACITY - 1, '0);
		queue_cmd(OP_REMOVE, 2, '0);
		queue_cmd(OP_POP, 0, '0);
		queue_cmd(OP_INSERT, CAPACITY, '0);
		queue_cmd(OP_CLEAR, 0, '0);
		queue_cmd(OP_GET, 0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part fully answered before random traffic starts
		wait_quiet();
		queue_random(RANDOM_ITEMS / 2);
		wait_quiet();
		queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
		wait_quiet();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d commands: push %0d append %0d insert %0d get %0d remove %0d",
			n_cmds, op_seen[OP_PUSH], op_seen[OP_APPEND], op_seen[OP_INSERT],
			op_seen[OP_GET], op_seen[OP_REMOVE]);
		$display("search %0d pop %0d clear %0d; %0d responses: ok %0d range %0d full %0d miss %0d",
			op_seen[OP_SEARCH], op_seen[OP_POP], op_seen[OP_CLEAR], n_rsps,
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
			status_seen[ST_MISS]);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
